// ===== rtl/sbi_pkg.sv =====
// Shared constants, codes and types of the sample buffer interpolator.
// Used by sbi_fetch, sbi_interp and the top level; depends on nothing.
package sbi_pkg;

   // Store geometry
   localparam int MAX_FRAMES = 4096;
   localparam int CHANNELS   = 2;
   localparam int FRAME_W    = $clog2(MAX_FRAMES);
   localparam int CHAN_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int COUNT_W    = 13;

   // The store is split into four banks by the two low frame bits, so that
   // four consecutive frames are always found in four different banks.
   localparam int BANKS      = 4;
   localparam int BANK_SEL_W = 2;
   localparam int ROW_W      = FRAME_W - BANK_SEL_W + CHAN_W;
   localparam int BANK_DEPTH = (MAX_FRAMES / BANKS) * CHANNELS;

   // Data formats
   localparam int SAMPLE_W = 16;
   localparam int POS_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int CLAMP_W  = FRAME_W + FRAC_W;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register selected by the word address bit of the register port
   localparam logic CSR_IDX_FRAMES = 1'b0;
   localparam logic CSR_IDX_MODE   = 1'b1;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef enum logic {
      MODE_LINEAR = 1'b0,
      MODE_CUBIC  = 1'b1
   } interp_mode_type;

   // Four neighbouring samples, already clamped at the buffer ends
   typedef struct packed {
      logic                       valid;
      logic                       zero;
      logic [FRAC_W-1:0]          frac;
      logic signed [SAMPLE_W-1:0] y0;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
      logic signed [SAMPLE_W-1:0] y3;
   } sbi_taps_type;

endpackage

// ===== rtl/sbi_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module sbi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sbi_fetch.sv =====
// Front end: position clamping, banked sample store and neighbour selection.
// Depends on sbi_pkg and sbi_ram.
module sbi_fetch (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 accept,
   input  logic [sbi_pkg::COUNT_W-1:0]          frames_in_use,
   input  logic                                 kind,
   input  logic [sbi_pkg::CHAN_W-1:0]           channel,
   input  logic [sbi_pkg::FRAME_W-1:0]          frame_index,
   input  logic signed [sbi_pkg::SAMPLE_W-1:0]  sample_value,
   input  logic signed [sbi_pkg::POS_W-1:0]     position,
   output sbi_pkg::sbi_taps_type                taps
);

   localparam int BSW = sbi_pkg::BANK_SEL_W;

   logic [sbi_pkg::COUNT_W-1:0]  frames_n;
   logic [sbi_pkg::COUNT_W-1:0]  last_n;
   logic [sbi_pkg::CLAMP_W-1:0]  max_pos;
   logic [sbi_pkg::CLAMP_W-1:0]  clamped_pos;

   // Stage 1
   logic                               s1_valid_ff;
   logic                               s1_kind_ff;
   logic [sbi_pkg::CHAN_W-1:0]         s1_chan_ff;
   logic [sbi_pkg::FRAME_W-1:0]        s1_frame_ff;
   logic [sbi_pkg::SAMPLE_W-1:0]       s1_value_ff;
   logic [sbi_pkg::FRAME_W-1:0]        s1_base_ff;
   logic [sbi_pkg::FRAC_W-1:0]         s1_frac_ff;
   logic                               s1_zero_ff;

   // Stage 2 (alongside the registered RAM outputs)
   logic                               s2_valid_ff;
   logic                               s2_valid_in;
   logic                               s2_zero_ff;
   logic [sbi_pkg::FRAC_W-1:0]         s2_frac_ff;
   logic [BSW-1:0]                     s2_rot_ff;
   logic                               s2_first_ff;
   logic                               s2_first_in;
   logic                               s2_has2_ff;
   logic                               s2_has2_in;
   logic                               s2_has3_ff;
   logic                               s2_has3_in;

   logic [sbi_pkg::FRAME_W-1:0]        win_start;
   logic                               store_write;
   logic [sbi_pkg::ROW_W-1:0]          rd_addr [sbi_pkg::BANKS];
   logic                               wr_en   [sbi_pkg::BANKS];
   logic [sbi_pkg::SAMPLE_W-1:0]       bank_q  [sbi_pkg::BANKS];
   logic signed [sbi_pkg::SAMPLE_W-1:0] raw    [sbi_pkg::BANKS];
   logic signed [sbi_pkg::SAMPLE_W-1:0] y1_sel;
   logic signed [sbi_pkg::SAMPLE_W-1:0] y2_sel;

   // Frame count above the store size counts as the store size.
   always_comb begin
      if (frames_in_use > sbi_pkg::COUNT_W'(sbi_pkg::MAX_FRAMES)) begin
         frames_n = sbi_pkg::COUNT_W'(sbi_pkg::MAX_FRAMES);
      end else begin
         frames_n = frames_in_use;
      end
      last_n  = frames_n - 1'b1;
      max_pos = {last_n[sbi_pkg::FRAME_W-1:0], {sbi_pkg::FRAC_W{1'b0}}};
   end

   // Clamp the Q16.16 position to 0 .. frames_n-1.
   always_comb begin
      if (position[sbi_pkg::POS_W-1]) begin
         clamped_pos = '0;
      end else if (position[sbi_pkg::POS_W-2:0] >
                   (sbi_pkg::POS_W-1)'(max_pos)) begin
         clamped_pos = max_pos;
      end else begin
         clamped_pos = position[sbi_pkg::CLAMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
      if (advance) begin
         s1_kind_ff  <= kind;
         s1_chan_ff  <= channel;
         s1_frame_ff <= frame_index;
         s1_value_ff <= sample_value;
         s1_base_ff  <= clamped_pos[sbi_pkg::CLAMP_W-1:sbi_pkg::FRAC_W];
         s1_frac_ff  <= clamped_pos[sbi_pkg::FRAC_W-1:0];
         s1_zero_ff  <= (frames_n == '0);
      end
   end

   // The window of four frames starts one before the base frame. Each bank
   // holds exactly one frame of the window; ends are fixed up after the read.
   always_comb begin
      win_start   = s1_base_ff - 1'b1;
      store_write = s1_valid_ff && (s1_kind_ff == sbi_pkg::KIND_WRITE) && advance;
      for (int b = 0; b < sbi_pkg::BANKS; b++) begin
         logic [BSW-1:0]              off;
         logic [sbi_pkg::FRAME_W-1:0] frame_b;
         off        = BSW'(b) - win_start[BSW-1:0];
         frame_b    = win_start + sbi_pkg::FRAME_W'(off);
         rd_addr[b] = {frame_b[sbi_pkg::FRAME_W-1:BSW], s1_chan_ff};
         wr_en[b]   = store_write && (s1_frame_ff[BSW-1:0] == BSW'(b));
      end
      s2_valid_in = s1_valid_ff && (s1_kind_ff == sbi_pkg::KIND_READ);
      s2_first_in = (s1_base_ff == '0);
      s2_has2_in  = ({1'b0, s1_base_ff} + sbi_pkg::COUNT_W'(1)) < frames_n;
      s2_has3_in  = ({1'b0, s1_base_ff} + sbi_pkg::COUNT_W'(2)) < frames_n;
   end

   for (genvar g = 0; g < sbi_pkg::BANKS; g++) begin : g_bank
      sbi_ram #(
         .WIDTH (sbi_pkg::SAMPLE_W),
         .DEPTH (sbi_pkg::BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr ({s1_frame_ff[sbi_pkg::FRAME_W-1:BSW], s1_chan_ff}),
         .wr_data (s1_value_ff),
         .rd_en   (advance),
         .rd_addr (rd_addr[g]),
         .rd_data (bank_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s2_valid_in;
      end
      if (advance) begin
         s2_zero_ff  <= s1_zero_ff;
         s2_frac_ff  <= s1_frac_ff;
         s2_rot_ff   <= win_start[BSW-1:0];
         s2_first_ff <= s2_first_in;
         s2_has2_ff  <= s2_has2_in;
         s2_has3_ff  <= s2_has3_in;
      end
   end

   // Put the bank outputs back in frame order and clamp at the buffer ends.
   always_comb begin
      for (int k = 0; k < sbi_pkg::BANKS; k++) begin
         raw[k] = $signed(bank_q[BSW'(s2_rot_ff + BSW'(k))]);
      end
      y1_sel     = raw[1];
      y2_sel     = s2_has2_ff ? raw[2] : y1_sel;
      taps.valid = s2_valid_ff;
      taps.zero  = s2_zero_ff;
      taps.frac  = s2_frac_ff;
      taps.y0    = s2_first_ff ? y1_sel : raw[0];
      taps.y1    = y1_sel;
      taps.y2    = y2_sel;
      taps.y3    = s2_has3_ff ? raw[3] : y2_sel;
   end

endmodule

// ===== rtl/sbi_interp.sv =====
// Arithmetic back end: linear and Catmull-Rom evaluation over four stages.
// Depends on sbi_pkg.
module sbi_interp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  sbi_pkg::interp_mode_type            interp_mode,
   input  sbi_pkg::sbi_taps_type               taps,
   output logic                                rsp_valid,
   output logic signed [sbi_pkg::SAMPLE_W-1:0] rsp_interpolated
);

   localparam int FW = sbi_pkg::FRAC_W;

   // Stage 3: polynomial coefficients
   logic signed [16:0] a1_in, d_in;
   logic signed [19:0] a2_in, a3_in;
   logic signed [19:0] y0_x, y1_x, y2_x, y3_x;
   logic               s3_valid_ff, s3_zero_ff;
   logic [FW-1:0]      s3_frac_ff;
   logic signed [15:0] s3_y1_ff;
   logic signed [16:0] s3_a1_ff, s3_d_ff;
   logic signed [19:0] s3_a2_ff, s3_a3_ff;

   // Stage 4: inner Horner step and the linear result
   logic signed [FW:0] f3_s;
   logic signed [36:0] prod_a3;
   logic signed [37:0] acc_a_in;
   logic signed [33:0] prod_d;
   logic signed [34:0] lin_sum;
   logic               s4_valid_ff, s4_zero_ff;
   logic [FW-1:0]      s4_frac_ff;
   logic signed [15:0] s4_y1_ff, s4_lin_ff;
   logic signed [16:0] s4_a1_ff;
   logic signed [37:0] s4_acc_a_ff;

   // Stage 5: middle Horner step, rounded back to Q16
   logic signed [FW:0] f4_s;
   logic signed [54:0] prod_a;
   logic signed [55:0] b_sum;
   logic               s5_valid_ff, s5_zero_ff;
   logic [FW-1:0]      s5_frac_ff;
   logic signed [15:0] s5_y1_ff, s5_lin_ff;
   logic signed [39:0] s5_c_ff;

   // Stage 6: outer Horner step, rounding, saturation and output register
   logic signed [FW:0] f5_s;
   logic signed [56:0] prod_c;
   logic signed [56:0] d_sum;
   logic signed [23:0] y_full;
   logic signed [15:0] cubic;
   logic signed [15:0] rsp_value_in;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_value_ff;

   always_comb begin
      y0_x  = 20'(taps.y0);
      y1_x  = 20'(taps.y1);
      y2_x  = 20'(taps.y2);
      y3_x  = 20'(taps.y3);
      a1_in = 17'(taps.y2) - 17'(taps.y0);
      d_in  = 17'(taps.y2) - 17'(taps.y1);
      a2_in = (y0_x <<< 1) - (20'sd5 * y1_x) + (y2_x <<< 2) - y3_x;
      a3_in = (20'sd3 * y1_x) - (20'sd3 * y2_x) + y3_x - y0_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= taps.valid;
      end
      if (advance) begin
         s3_zero_ff <= taps.zero;
         s3_frac_ff <= taps.frac;
         s3_y1_ff   <= taps.y1;
         s3_a1_ff   <= a1_in;
         s3_d_ff    <= d_in;
         s3_a2_ff   <= a2_in;
         s3_a3_ff   <= a3_in;
      end
   end

   always_comb begin
      f3_s     = $signed({1'b0, s3_frac_ff});
      prod_a3  = s3_a3_ff * f3_s;
      acc_a_in = (38'(s3_a2_ff) <<< FW) + 38'(prod_a3);
      prod_d   = s3_d_ff * f3_s;
      lin_sum  = (35'(s3_y1_ff) <<< FW) + 35'(prod_d) + 35'sd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_zero_ff  <= s3_zero_ff;
         s4_frac_ff  <= s3_frac_ff;
         s4_y1_ff    <= s3_y1_ff;
         s4_a1_ff    <= s3_a1_ff;
         s4_acc_a_ff <= acc_a_in;
         s4_lin_ff   <= lin_sum[31:16];
      end
   end

   always_comb begin
      f4_s   = $signed({1'b0, s4_frac_ff});
      prod_a = s4_acc_a_ff * f4_s;
      b_sum  = (56'(s4_a1_ff) <<< 32) + 56'(prod_a) + 56'sd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_zero_ff <= s4_zero_ff;
         s5_frac_ff <= s4_frac_ff;
         s5_y1_ff   <= s4_y1_ff;
         s5_lin_ff  <= s4_lin_ff;
         s5_c_ff    <= b_sum[55:16];
      end
   end

   always_comb begin
      f5_s   = $signed({1'b0, s5_frac_ff});
      prod_c = s5_c_ff * f5_s;
      d_sum  = (57'(s5_y1_ff) <<< 33) + prod_c + (57'sd1 <<< 32);
      y_full = d_sum[56:33];
      if (y_full > 24'sd32767) begin
         cubic = 16'sh7FFF;
      end else if (y_full < -24'sd32768) begin
         cubic = -16'sh8000;
      end else begin
         cubic = y_full[15:0];
      end
      if (s5_zero_ff) begin
         rsp_value_in = '0;
      end else if (interp_mode == sbi_pkg::MODE_CUBIC) begin
         rsp_value_in = cubic;
      end else begin
         rsp_value_in = s5_lin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interpolated = rsp_value_ff;

endmodule

// ===== rtl/sample_buffer_interpolator_core.sv =====
// Sample buffer interpolator: a read beat is accepted into stage 1 and moves on
// to its result in the output register; one beat is taken every cycle while
// the pipeline advances. The six-stage pipeline advances as a whole whenever
// the output register is empty or its beat is being taken.
// Synchronous reset clears the pipeline valid bits and both registers; the
// sample store itself is not cleared and holds garbage until written.
module sample_buffer_interpolator_core (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [sbi_pkg::CHAN_W-1:0]          req_channel,
   input  logic [sbi_pkg::FRAME_W-1:0]         req_frame_index,
   input  logic signed [sbi_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic signed [sbi_pkg::POS_W-1:0]    req_position,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sbi_pkg::SAMPLE_W-1:0] rsp_interpolated,
   // Register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sbi_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sbi_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sbi_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic                             advance;
   logic                             accept;
   logic                             csr_write;
   logic [sbi_pkg::COUNT_W-1:0]      frames_in_use_ff;
   sbi_pkg::interp_mode_type         interp_mode_ff;
   sbi_pkg::sbi_taps_type            taps;

   // The whole pipeline moves together. It only stops when a finished beat
   // sits in the output register and the receiver is stalling, so a new
   // request is still taken while a result waits, as long as it is being
   // drained. Requests are refused throughout reset.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = reset || !advance;
   assign accept    = req_valid && !req_stall;

   // Register port. Every access completes without wait states; the word
   // address bit alone selects the register, the byte offset is ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= '0;
         interp_mode_ff   <= sbi_pkg::MODE_LINEAR;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            sbi_pkg::CSR_IDX_FRAMES: begin
               frames_in_use_ff <= csr_pwdata[sbi_pkg::COUNT_W-1:0];
            end
            sbi_pkg::CSR_IDX_MODE: begin
               interp_mode_ff <= sbi_pkg::interp_mode_type'(csr_pwdata[0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sbi_pkg::CSR_IDX_FRAMES: begin
            csr_prdata = sbi_pkg::CSR_DATA_W'(frames_in_use_ff);
         end
         sbi_pkg::CSR_IDX_MODE: begin
            csr_prdata = sbi_pkg::CSR_DATA_W'(interp_mode_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // Stages 1 and 2: position clamping, then the banked store access. Writes
   // land in the store at the same stage at which reads look it up, so a read
   // always sees every write that was accepted before it.
   sbi_fetch u_fetch (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .accept        (accept),
      .frames_in_use (frames_in_use_ff),
      .kind          (req_kind),
      .channel       (req_channel),
      .frame_index   (req_frame_index),
      .sample_value  (req_sample_value),
      .position      (req_position),
      .taps          (taps)
   );

   // Stages 3 to 6: coefficients, three Horner steps and the output register.
   // Only read beats carry a valid bit past the store, so writes leave no
   // trace on the response channel.
   sbi_interp u_interp (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .interp_mode      (interp_mode_ff),
      .taps             (taps),
      .rsp_valid        (rsp_valid),
      .rsp_interpolated (rsp_interpolated)
   );

endmodule

// ===== rtl/sbi_checker.sv =====
// Port-level checks of the sample buffer interpolator, bound to the top level.
// Depends only on the top level's ports.
module sbi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_interpolated
);

   // A stalled response beat stays and keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_interpolated))
      else $error("stalled response beat dropped or changed");

   // Requests are only held off by back-pressure on the response side.
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled without response back-pressure");

   // Reset empties the output register.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // A read beat with no back-pressure on its way out reaches the output register.
   assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && !req_stall && req_kind, 6) &&
       !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) &&
       !$past(reset, 4) && !$past(reset, 5) && !$past(reset, 6) &&
       !$past(rsp_stall, 1) && !$past(rsp_stall, 2) && !$past(rsp_stall, 3) &&
       !$past(rsp_stall, 4) && !$past(rsp_stall, 5)) |-> rsp_valid)
      else $error("read beat did not produce a response in time");

endmodule

bind sample_buffer_interpolator_core sbi_checker u_sbi_checker (.*);
